### sv/i2crts_pkg.sv
`timescale 1ns / 1ps
// Package for the I2C register transfer sequencer.
// Holds the event codes and the request and response beat types; no dependencies.
package i2crts_pkg;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_RXB   = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int STORE_BYTES = WORD_W / BYTE_W;

    localparam logic DIR_WRITE_BIT = 1'b0;
    localparam logic DIR_READ_BIT  = 1'b1;

    typedef struct packed {
        action_t             action;
        logic [6:0]          dev_addr;
        logic [7:0]          reg_addr;
        logic                write_flag;
        logic [2:0]          byte_count;
        logic [WORD_W-1:0]   initial_word;
        logic [BYTE_W-1:0]   rx_byte;
    } req_t;

    typedef struct packed {
        logic                issue_start;
        logic                issue_stop;
        logic                issue_ack;
        logic                issue_nack;
        logic                tx_valid;
        logic [BYTE_W-1:0]   tx_byte;
        logic [WORD_W-1:0]   data_word;
        logic                done_res;
        logic                busy_res;
        logic                error;
    } rsp_t;

endpackage

### sv/i2c_register_transfer_sequencer_core.sv
`timescale 1ns / 1ps
// I2C master register transfer sequencer: one bus event in, one command beat out.
// Depends on i2crts_pkg.
//
//  channel | direction | signals                    | beat
//  --------+-----------+----------------------------+------------------------
//  req     | in        | req_valid, req_ready, req  | one bus event
//  rsp     | out       | rsp_valid, rsp_ready, rsp  | commands, flags, word
//
// One event per clock while req_ready is high. The sequencer state updates at the
// accepting edge and the response beat is registered there, valid the cycle after.
// req_ready is low only while a response waits and rsp_ready is low.
// rst_n clears the phase, counters and stored transfer fields, and empties the
// response register.
module i2c_register_transfer_sequencer_core #(
    parameter int WORD_BYTES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  i2crts_pkg::req_t   req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output i2crts_pkg::rsp_t   rsp
);

    localparam int CNT_W = $clog2(WORD_BYTES + 1);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_REG   = 3'd2,
        PH_PREP  = 3'd3,
        PH_RECV  = 3'd4,
        PH_WDATA = 3'd5,
        PH_STOP  = 3'd6
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [CNT_W-1:0]                bytes_left_reg, bytes_left_next;
    logic [i2crts_pkg::WORD_W-1:0]   word_reg, word_next;
    logic [6:0]                      taddr_reg, taddr_next;
    logic [7:0]                      treg_reg, treg_next;
    logic                            dirw_reg, dirw_next;
    logic                            rsp_valid_reg;
    i2crts_pkg::rsp_t                rsp_reg, rsp_next;

    logic                            accept;
    logic [CNT_W-1:0]                count_clamped;
    logic [CNT_W-1:0]                pos;
    logic [i2crts_pkg::BYTE_W-1:0]   sel_byte;
    logic [i2crts_pkg::WORD_W-1:0]   word_put;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (req.byte_count == 3'd0)
            count_clamped = CNT_W'(1);
        else if (32'(req.byte_count) > WORD_BYTES)
            count_clamped = CNT_W'(WORD_BYTES);
        else
            count_clamped = CNT_W'(req.byte_count);
    end

    assign pos = bytes_left_reg - CNT_W'(1);

    // Positions above the 32-bit word read as zero and drop writes.
    always_comb
    begin
        sel_byte = '0;
        word_put = word_reg;
        for (int k = 0; k < i2crts_pkg::STORE_BYTES; k++)
        begin
            if (32'(pos) == k)
            begin
                sel_byte = word_reg[k*i2crts_pkg::BYTE_W +: i2crts_pkg::BYTE_W];
                word_put[k*i2crts_pkg::BYTE_W +: i2crts_pkg::BYTE_W] = req.rx_byte;
            end
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        word_next       = word_reg;
        taddr_next      = taddr_reg;
        treg_next       = treg_reg;
        dirw_next       = dirw_reg;
        rsp_next        = '0;

        case (req.action)
            i2crts_pkg::ACT_START:
            begin
                if (phase_reg != PH_IDLE)
                    rsp_next.error = 1'b1;
                else
                begin
                    taddr_next           = req.dev_addr;
                    treg_next            = req.reg_addr;
                    dirw_next            = req.write_flag;
                    bytes_left_next      = count_clamped;
                    word_next            = req.initial_word;
                    phase_next           = PH_ADDR;
                    rsp_next.issue_start = 1'b1;
                    rsp_next.tx_valid    = 1'b1;
                    rsp_next.tx_byte     = {req.dev_addr, i2crts_pkg::DIR_WRITE_BIT};
                end
            end
            i2crts_pkg::ACT_ACK:
            begin
                case (phase_reg)
                    PH_ADDR:
                    begin
                        rsp_next.tx_valid = 1'b1;
                        rsp_next.tx_byte  = treg_reg;
                        phase_next        = dirw_reg ? PH_WDATA : PH_REG;
                    end
                    PH_REG:
                    begin
                        rsp_next.issue_start = 1'b1;
                        rsp_next.tx_valid    = 1'b1;
                        rsp_next.tx_byte     = {taddr_reg, i2crts_pkg::DIR_READ_BIT};
                        phase_next           = PH_PREP;
                    end
                    PH_PREP:
                        phase_next = PH_RECV;
                    PH_WDATA:
                    begin
                        if (bytes_left_reg != '0)
                        begin
                            bytes_left_next   = pos;
                            rsp_next.tx_valid = 1'b1;
                            rsp_next.tx_byte  = sel_byte;
                        end
                        else
                        begin
                            rsp_next.issue_stop = 1'b1;
                            phase_next          = PH_STOP;
                        end
                    end
                    default:
                        rsp_next.error = 1'b1;
                endcase
            end
            i2crts_pkg::ACT_RXB:
            begin
                if (phase_reg != PH_RECV || bytes_left_reg == '0)
                    rsp_next.error = 1'b1;
                else
                begin
                    bytes_left_next = pos;
                    word_next       = word_put;
                    if (pos != '0)
                        rsp_next.issue_ack = 1'b1;
                    else
                    begin
                        rsp_next.issue_nack = 1'b1;
                        rsp_next.issue_stop = 1'b1;
                        phase_next          = PH_STOP;
                    end
                end
            end
            default:
            begin
                if (phase_reg != PH_STOP)
                    rsp_next.error = 1'b1;
                else
                begin
                    rsp_next.done_res = 1'b1;
                    phase_next        = PH_IDLE;
                end
            end
        endcase

        rsp_next.data_word = word_next;
        rsp_next.busy_res  = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            word_reg       <= '0;
            taddr_reg      <= '0;
            treg_reg       <= '0;
            dirw_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                word_reg       <= word_next;
                taddr_reg      <= taddr_next;
                treg_reg       <= treg_next;
                dirw_reg       <= dirw_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (rsp_ready)
                rsp_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_IDLE && req.action == i2crts_pkg::ACT_START
        |=> rsp_valid && rsp.busy_res && rsp.issue_start && rsp.tx_valid)
        else $error("start from idle did not open a transfer");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.done_res |-> phase_reg == PH_IDLE && !rsp.busy_res)
        else $error("done reported while phase not idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bytes_left_reg) <= WORD_BYTES)
        else $error("byte counter exceeds word size");

    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.action != i2crts_pkg::ACT_START && phase_reg == PH_IDLE
        |=> rsp.error && $stable(phase_reg) && $stable(word_reg))
        else $error("stray event changed state");
`endif

endmodule
